// ===== src/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    // Field widths
    localparam int CP_W   = 21;  // code point width
    localparam int RUN_W  = 3;   // results per byte, 0..4
    localparam int CNT_W  = 2;   // expected / held byte counters

    // Byte class masks and tags
    localparam logic [7:0] C_TOP2     = 8'o300;  // top two bits
    localparam logic [7:0] C_CONT     = 8'o200;  // continuation tag 10xxxxxx
    localparam logic [7:0] C_TOP3     = 8'o340;  // top three bits / 3-byte tag
    localparam logic [7:0] C_TOP4     = 8'o360;  // top four bits / 4-byte tag
    localparam logic [7:0] C_TOP5     = 8'o370;  // top five bits
    localparam logic [7:0] C_PAY2     = 8'o037;  // payload of a 2-byte lead
    localparam logic [7:0] C_PAY3     = 8'o017;  // payload of a 3-byte lead
    localparam logic [7:0] C_PAY4     = 8'o007;  // payload of a 4-byte lead
    localparam logic [7:0] C_PAY_CONT = 8'o077;  // payload of a continuation

    // Results caused by one byte: count-1 malformed zeros, then a tail result
    typedef struct packed {
        logic [RUN_W-1:0] count;
        logic [CP_W-1:0]  cp;
        logic             bad;
    } t_run;

endpackage

// ===== src/u8d_decode.sv =====
// ----------------------------------------------------------------------------
// u8d_decode
// Sequence state and single-pass byte decode; produces the run of results
// that one accepted byte causes.
// ----------------------------------------------------------------------------
module u8d_decode (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_end_of_text,
    output u8d_pkg::t_run            o_run
);

    logic [u8d_pkg::CP_W-1:0]  r_bits, n_bits;
    logic [u8d_pkg::CNT_W-1:0] r_expected, n_expected;
    logic [u8d_pkg::CNT_W-1:0] r_held, n_held;

    logic                      is_cont;
    logic                      seq_open;
    logic [u8d_pkg::CP_W-1:0]  cat_bits;
    logic [u8d_pkg::CNT_W-1:0] cat_held;
    logic [u8d_pkg::CNT_W-1:0] cat_expected;
    logic [u8d_pkg::CNT_W-1:0] pre_bad;
    logic [7:0]                b;

    assign b        = i_data_byte;
    assign is_cont  = (b & u8d_pkg::C_TOP2) == u8d_pkg::C_CONT;
    assign seq_open = r_expected != '0;

    // Append a continuation payload
    assign cat_bits     = {r_bits[u8d_pkg::CP_W-7:0], b[5:0] & u8d_pkg::C_PAY_CONT[5:0]};
    assign cat_held     = r_held + 2'd1;
    assign cat_expected = r_expected - 2'd1;
    assign pre_bad      = seq_open ? r_held : '0;

    // Decode one byte
    always_comb begin
        n_bits     = r_bits;
        n_expected = r_expected;
        n_held     = r_held;
        o_run.count = '0;
        o_run.cp    = '0;
        o_run.bad   = 1'b1;

        if (seq_open && is_cont) begin
            if (cat_expected == '0) begin
                o_run.count = u8d_pkg::RUN_W'(1);
                o_run.cp    = cat_bits;
                o_run.bad   = 1'b0;
                n_expected  = '0;
                n_held      = '0;
            end else if (i_end_of_text) begin
                o_run.count = u8d_pkg::RUN_W'(cat_held);
                n_expected  = '0;
                n_held      = '0;
            end else begin
                n_bits     = cat_bits;
                n_expected = cat_expected;
                n_held     = cat_held;
            end
        end else begin
            // held bytes of a broken sequence, then the byte as a lead
            o_run.count = u8d_pkg::RUN_W'(pre_bad);
            n_expected  = '0;
            n_held      = '0;
            if (!b[7]) begin
                o_run.count = u8d_pkg::RUN_W'(pre_bad) + u8d_pkg::RUN_W'(1);
                o_run.cp    = u8d_pkg::CP_W'(b);
                o_run.bad   = 1'b0;
            end else if ((b & u8d_pkg::C_TOP3) == u8d_pkg::C_TOP2) begin
                if (i_end_of_text) begin
                    o_run.count = u8d_pkg::RUN_W'(pre_bad) + u8d_pkg::RUN_W'(1);
                end else begin
                    n_bits     = u8d_pkg::CP_W'(b & u8d_pkg::C_PAY2);
                    n_expected = 2'd1;
                    n_held     = 2'd1;
                end
            end else if ((b & u8d_pkg::C_TOP4) == u8d_pkg::C_TOP3) begin
                if (i_end_of_text) begin
                    o_run.count = u8d_pkg::RUN_W'(pre_bad) + u8d_pkg::RUN_W'(1);
                end else begin
                    n_bits     = u8d_pkg::CP_W'(b & u8d_pkg::C_PAY3);
                    n_expected = 2'd2;
                    n_held     = 2'd1;
                end
            end else if ((b & u8d_pkg::C_TOP5) == u8d_pkg::C_TOP4) begin
                if (i_end_of_text) begin
                    o_run.count = u8d_pkg::RUN_W'(pre_bad) + u8d_pkg::RUN_W'(1);
                end else begin
                    n_bits     = u8d_pkg::CP_W'(b & u8d_pkg::C_PAY4);
                    n_expected = 2'd3;
                    n_held     = 2'd1;
                end
            end else begin
                // stray continuation or F8-FF
                o_run.count = u8d_pkg::RUN_W'(pre_bad) + u8d_pkg::RUN_W'(1);
            end
        end

        // end of text always closes the sequence
        if (i_end_of_text) begin
            n_expected = '0;
            n_held     = '0;
        end
    end

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
            r_held     <= '0;
        end else if (i_fire) begin
            r_expected <= n_expected;
            r_held     <= n_held;
        end
    end

    // Gathered payload bits
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_bits <= n_bits;
        end
    end

    // An open sequence always holds its lead
    a_open_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_expected != '0) |-> (r_held != '0))
        else $error("open sequence with no held bytes");

    // Held plus expected never exceeds a four byte sequence
    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (({1'b0, r_held} + {1'b0, r_expected}) <= 3'd4))
        else $error("sequence length out of range");

endmodule

// ===== src/u8d_emit.sv =====
// ----------------------------------------------------------------------------
// u8d_emit
// Result register: holds one byte's run and hands out its results one per
// transaction; takes the next run as the last result leaves.
// ----------------------------------------------------------------------------
module u8d_emit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  u8d_pkg::t_run            i_run,
    output logic                     o_ready,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [u8d_pkg::CP_W-1:0] o_code_point,
    output logic                     o_malformed,
    output logic                     o_last_of_run
);

    logic [u8d_pkg::RUN_W-1:0] r_left, n_left;
    logic [u8d_pkg::CP_W-1:0]  r_cp;
    logic                      r_bad;
    logic                      out_fire;
    logic                      on_tail;

    assign on_tail  = r_left == u8d_pkg::RUN_W'(1);
    assign o_valid  = r_left != '0;
    assign out_fire = o_valid && !i_stall;
    assign o_ready  = (r_left == '0) || (on_tail && out_fire);

    // Leading results are malformed zeros; the tail carries the run's value
    assign o_code_point  = on_tail ? r_cp : '0;
    assign o_malformed   = on_tail ? r_bad : 1'b1;
    assign o_last_of_run = on_tail;

    // Remaining result count
    always_comb begin
        n_left = r_left;
        if (i_fire) begin
            n_left = i_run.count;
        end else if (out_fire) begin
            n_left = r_left - u8d_pkg::RUN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    // Tail payload
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_cp  <= i_run.cp;
            r_bad <= i_run.bad;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left <= u8d_pkg::RUN_W'(4)))
        else $error("run count out of range");

    // No byte is taken while more than the tail result is pending
    a_no_early_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left > u8d_pkg::RUN_W'(1)) |-> !i_fire)
        else $error("byte taken with results pending");

    // A delivered non-tail result leaves one fewer behind
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !on_tail) |=> (r_left == $past(r_left) - u8d_pkg::RUN_W'(1)))
        else $error("result count did not step down");

endmodule

// ===== src/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code point decoder, one byte per transaction in,
// zero to four code point results per byte out.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     i_valid / o_stall    i_data_byte, i_end_of_text
//  output    o_valid / i_stall    o_code_point, o_malformed, o_last_of_run
//
//  A byte is decoded in the cycle it is taken; its results appear from the
//  result register on the next cycle. A byte giving several results holds
//  the input while the single result register drains them, one result per
//  cycle while i_stall is low.
//  Synchronous active-low reset clears the open sequence and the results.
//  o_stall follows i_stall only while the last result of a run is pending.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_end_of_text,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [u8d_pkg::CP_W-1:0] o_code_point,
    output logic                     o_malformed,
    output logic                     o_last_of_run
);

    u8d_pkg::t_run run;
    logic          ready;
    logic          in_fire;

    assign o_stall = !ready;
    assign in_fire = i_valid && ready;

    // Byte decode and sequence state
    u8d_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_run         (run)
    );

    // Result register and output handshake
    u8d_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_run         (run),
        .o_ready       (ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_malformed   (o_malformed),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== sim/utf8_stream_decoder_top_test.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_test
// Self-checking testbench for the UTF-8 stream decoder. Bytes go in through
// the valid/stall input channel, and a built-in decoder model predicts the
// code point results for each accepted byte. The output channel is compared
// result by result against that model. Directed bytes cover each lead type,
// field extremes and the error cases. Random texts follow, with idle bursts
// and stalls on both sides, one long output hold, and a quiet final stretch.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        logic [u8d_pkg::CP_W-1:0] cp;
        logic                     bad;
        logic                     last;
    } t_cp_result;

    // DUT ports, all inputs known from time zero
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_valid       = 1'b0;
    logic [7:0]               i_data_byte   = 8'h00;
    logic                     i_end_of_text = 1'b0;
    logic                     i_stall       = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic [u8d_pkg::CP_W-1:0] o_code_point;
    logic                     o_malformed;
    logic                     o_last_of_run;

    // Decoder model state
    logic [u8d_pkg::CP_W-1:0] seq_bits = '0;
    logic [1:0]               seq_need = '0;
    logic [1:0]               seq_held = '0;

    t_cp_result cp_expected[$];
    logic [7:0] text_buf[$];

    int error_count    = 0;
    int cycle_count    = 0;
    int items_sent     = 0;
    bit src_gaps_on    = 1'b0;
    bit sink_stalls_on = 1'b0;
    int sink_hold_left = 0;
    int sink_burst     = 0;

    utf8_stream_decoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_malformed   (o_malformed),
        .o_last_of_run (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("utf8_stream_decoder_top_test: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic t_cp_result make_result(input logic [u8d_pkg::CP_W-1:0] cp,
                                               input logic bad);
        t_cp_result r;
        r.cp   = cp;
        r.bad  = bad;
        r.last = 1'b0;
        return r;
    endfunction

    // Decoder model: consume one byte, queue the code points it produces
    function automatic void predict_code_points(input logic [7:0] b, input logic eot);
        t_cp_result run[$];
        logic       as_lead;
        as_lead = 1'b1;
        if (seq_need != 2'd0) begin
            if ((b & u8d_pkg::C_TOP2) == u8d_pkg::C_CONT) begin
                as_lead  = 1'b0;
                seq_bits = {seq_bits[u8d_pkg::CP_W-7:0], b[5:0]};
                seq_held = seq_held + 2'd1;
                seq_need = seq_need - 2'd1;
                if (seq_need == 2'd0) begin
                    run.push_back(make_result(seq_bits, 1'b0));
                    seq_bits = '0;
                    seq_held = '0;
                end else if (eot) begin
                    repeat (seq_held) run.push_back(make_result('0, 1'b1));
                end
            end else begin
                // broken sequence: one malformed zero per held byte
                repeat (seq_held) run.push_back(make_result('0, 1'b1));
                seq_bits = '0;
                seq_need = '0;
                seq_held = '0;
            end
        end

        if (as_lead) begin
            if (b[7] == 1'b0) begin
                run.push_back(make_result(u8d_pkg::CP_W'(b), 1'b0));
            end else if ((b & u8d_pkg::C_TOP3) == u8d_pkg::C_TOP2) begin
                if (eot) run.push_back(make_result('0, 1'b1));
                else begin
                    seq_bits = u8d_pkg::CP_W'(b & u8d_pkg::C_PAY2);
                    seq_need = 2'd1;
                    seq_held = 2'd1;
                end
            end else if ((b & u8d_pkg::C_TOP4) == u8d_pkg::C_TOP3) begin
                if (eot) run.push_back(make_result('0, 1'b1));
                else begin
                    seq_bits = u8d_pkg::CP_W'(b & u8d_pkg::C_PAY3);
                    seq_need = 2'd2;
                    seq_held = 2'd1;
                end
            end else if ((b & u8d_pkg::C_TOP5) == u8d_pkg::C_TOP4) begin
                if (eot) run.push_back(make_result('0, 1'b1));
                else begin
                    seq_bits = u8d_pkg::CP_W'(b & u8d_pkg::C_PAY4);
                    seq_need = 2'd3;
                    seq_held = 2'd1;
                end
            end else begin
                run.push_back(make_result('0, 1'b1));
            end
        end

        // end of text always closes any open sequence
        if (eot) begin
            seq_bits = '0;
            seq_need = '0;
            seq_held = '0;
        end

        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        foreach (run[k]) cp_expected.push_back(run[k]);
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_cp_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cp_expected.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_code_point), 32'd0);
            end else begin
                want = cp_expected.pop_front();
                if (o_code_point !== want.cp)
                    report_mismatch("code_point", 32'(o_code_point), 32'(want.cp));
                if (o_malformed !== want.bad)
                    report_mismatch("malformed", 32'(o_malformed), 32'(want.bad));
                if (o_last_of_run !== want.last)
                    report_mismatch("last_of_run", 32'(o_last_of_run), 32'(want.last));
            end
        end
    end

    // Receiver: long hold when requested, else random stall bursts
    always @(negedge i_clk) begin
        if (sink_hold_left > 0) begin
            i_stall <= 1'b1;
            sink_hold_left--;
        end else if (sink_burst > 0) begin
            i_stall <= 1'b1;
            sink_burst--;
        end else if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
            i_stall    <= 1'b1;
            sink_burst = $urandom_range(1, 13) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Offer one byte, hold it until taken, then predict its results
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_stall);
        predict_code_points(b, eot);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (cp_expected.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] rand_lead(input int len);
        case (len)
            2:       return 8'hC0 | 8'($urandom_range(0, 31));
            3:       return 8'hE0 | 8'($urandom_range(0, 15));
            4:       return 8'hF0 | 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    // Append one character of the given kind to the text buffer
    task automatic add_char(input int kind);
        int len;
        int n_cont;
        if (kind <= 5) len = 1;
        else if (kind <= 9) len = 2;
        else if (kind <= 13) len = 3;
        else len = 4;
        if (kind == 17) begin
            text_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 18) begin
            // truncated sequence
            len    = $urandom_range(2, 4);
            n_cont = $urandom_range(0, len - 2);
            text_buf.push_back(rand_lead(len));
            repeat (n_cont) text_buf.push_back(rand_cont());
        end else if (kind == 19) begin
            text_buf.push_back(rand_cont());
        end else begin
            text_buf.push_back(rand_lead(len));
            repeat (len - 1) text_buf.push_back(rand_cont());
        end
    endtask

    // Build and send one random text, end of text on its final byte
    task automatic send_random_text();
        int n_chars;
        text_buf.delete();
        n_chars = $urandom_range(1, 12);
        repeat (n_chars) add_char($urandom_range(0, 19));
        foreach (text_buf[k]) send_byte(text_buf[k], k == text_buf.size() - 1);
    endtask

    // Well-formed characters at the extremes, overlong and surrogate included
    task automatic test_valid_sequences();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    // Stray continuation, bad leads, sequences cut short by a new lead
    task automatic test_broken_sequences();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h41, 1'b0);
        // three held bytes plus a bad lead: four results from one byte
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
    endtask

    // End of text on a continuation inside a sequence, and on a bare lead
    task automatic test_end_of_text();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC3, 1'b1);
    endtask

    // Receiver holds off while bytes keep coming, so the input stalls
    task automatic test_output_hold();
        src_gaps_on    = 1'b0;
        sink_hold_left = 250;
        repeat (6) send_random_text();
        src_gaps_on = 1'b1;
    endtask

    // Sender pauses until every result is out, then resumes
    task automatic test_drain_pause();
        repeat (3) send_random_text();
        wait_for_drain();
        repeat (3) send_random_text();
    endtask

    task automatic test_random_texts(input int item_goal);
        int stop_at;
        stop_at = items_sent + item_goal;
        while (items_sent < stop_at) send_random_text();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        test_valid_sequences();
        test_broken_sequences();
        test_end_of_text();
        test_output_hold();
        test_drain_pause();
        test_random_texts(230);

        // quiet stretch with no idling on either side
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_texts(80);

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("utf8_stream_decoder_top_test: done, clean");
        end else begin
            $display("utf8_stream_decoder_top_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/u8d_pkg.sv
src/u8d_decode.sv
src/u8d_emit.sv
src/utf8_stream_decoder_top.sv
sim/utf8_stream_decoder_top_test.sv
